// File: hdl/rmf_pkg.sv
// Shared types, constants and helpers for the RGB 3x3 median filter.
package rmf_pkg;

	localparam int CH_BITS       = 8;
	localparam int PIX_BITS      = 3 * CH_BITS;
	localparam int SUM_BITS      = CH_BITS + 2;
	localparam int WIN_N         = 9;
	localparam int MED_RANK      = 4;
	localparam int RANK_BITS     = 4;

	localparam int CFG_IDX_BITS  = 1;
	localparam int CFG_W_BITS    = 9;
	localparam int CFG_H_BITS    = 8;
	localparam int CFG_DATA_BITS = CFG_W_BITS;
	localparam int CFG_W_MAX     = (1 << CFG_W_BITS) - 1;
	localparam int CFG_H_MAX     = (1 << CFG_H_BITS) - 1;
	localparam int W_DEFAULT     = 320;
	localparam int H_DEFAULT     = 240;

	localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_HEIGHT = 1'b1;

	localparam int OUT_DEPTH     = 5;
	localparam int OUT_CNT_BITS  = $clog2(OUT_DEPTH + 1);
	localparam int OUT_PTR_BITS  = $clog2(OUT_DEPTH);

	typedef struct packed {
		logic [CH_BITS-1:0] red;
		logic [CH_BITS-1:0] green;
		logic [CH_BITS-1:0] blue;
	} pix_t;

	typedef pix_t [WIN_N-1:0] win_t;

	typedef struct packed {
		logic border;
		logic last;
	} pos_ctl_t;

	typedef struct packed {
		logic last;
		pix_t pix;
	} out_beat_t;

	function automatic logic [SUM_BITS-1:0] pix_sum(input pix_t p);
		return SUM_BITS'(p.red) + SUM_BITS'(p.green) + SUM_BITS'(p.blue);
	endfunction

endpackage

// File: hdl/rgb_median_filter_3x3.sv
// Top level of the streaming RGB 3x3 median filter.
// Path to m_tvalid: the input beat releasing a result (the beat frame_width+1 positions
// later in raster order) passes stage 1, the median stages and the result queue.
// Throughput: one beat per cycle while s_tready, a 5-entry result queue credit, is set.
// Reset: counters cleared, width 320 and height 240; line memories are not cleared.
module rgb_median_filter_3x3
	import rmf_pkg::*;
#(
	parameter int MAX_WIDTH  = 320,
	parameter int MAX_HEIGHT = 240
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     s_tvalid,
	output logic                     s_tready,
	input  logic [PIX_BITS-1:0]      s_tdata,   // red, green, blue
	input  logic                     s_tuser,   // drain
	output logic                     m_tvalid,
	input  logic                     m_tready,
	output logic [PIX_BITS-1:0]      m_tdata,   // out_red, out_green, out_blue
	output logic                     m_tlast,   // frame_end
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [CFG_DATA_BITS-1:0] cfg_data
);

	localparam int WMAX  = (MAX_WIDTH < CFG_W_MAX) ? MAX_WIDTH : CFG_W_MAX;
	localparam int HMAX  = (MAX_HEIGHT < CFG_H_MAX) ? MAX_HEIGHT : CFG_H_MAX;
	localparam int WB    = $clog2(WMAX + 1);
	localparam int HB    = $clog2(HMAX + 1);
	localparam int RB    = $clog2(HMAX + 2);
	localparam int AW    = $clog2(MAX_WIDTH);
	localparam int W_RST = (MAX_WIDTH < W_DEFAULT) ? MAX_WIDTH : W_DEFAULT;
	localparam int H_RST = (MAX_HEIGHT < H_DEFAULT) ? MAX_HEIGHT : H_DEFAULT;

	logic [WB-1:0] w_q, w_wr, in_col_q, out_col_q;
	logic [HB-1:0] h_q, h_wr, out_row_q;
	logic [RB-1:0] in_row_q;

	logic     in_beat;
	pix_t     s0_pix;
	logic     s0_started, s0_last, col_end, out_col_end, out_row_last;
	pos_ctl_t s0_ctl;
	logic [WB+AW-1:0] col_ext, ocol_ext;

	logic          v_s1, started_s1;
	pix_t          cur_s1;
	pos_ctl_t      ctl_s1;
	logic [AW-1:0] col_s1;

	pix_t top, mid, copy;
	win_t win_q, win_n;

	logic                    med_valid;
	out_beat_t               med_beat, head_beat;
	logic [1:0]              inflight;
	logic [OUT_CNT_BITS-1:0] fifo_cnt;
	logic [OUT_CNT_BITS:0]   credit_used;

	// configuration: clamp on write so the datapath never sees 0 or oversize dims
	always_comb begin
		if (cfg_data[CFG_W_BITS-1:0] == '0) begin
			w_wr = WB'(1);
		end else if (int'(cfg_data[CFG_W_BITS-1:0]) > WMAX) begin
			w_wr = WB'(WMAX);
		end else begin
			w_wr = WB'(cfg_data[CFG_W_BITS-1:0]);
		end
		if (cfg_data[CFG_H_BITS-1:0] == '0) begin
			h_wr = HB'(1);
		end else if (int'(cfg_data[CFG_H_BITS-1:0]) > HMAX) begin
			h_wr = HB'(HMAX);
		end else begin
			h_wr = HB'(cfg_data[CFG_H_BITS-1:0]);
		end
	end

	assign cfg_ready = 1'b1;

	assign credit_used = (OUT_CNT_BITS+1)'(fifo_cnt) + (OUT_CNT_BITS+1)'(v_s1) +
		(OUT_CNT_BITS+1)'(inflight);
	assign s_tready = int'(credit_used) < OUT_DEPTH;
	assign in_beat  = s_tvalid && s_tready;

	// stage 0: position bookkeeping and line memory reads
	always_comb begin
		if (s_tuser || int'(in_row_q) >= int'(h_q)) begin
			s0_pix = '0;
		end else begin
			s0_pix.red   = s_tdata[CH_BITS-1:0];
			s0_pix.green = s_tdata[2*CH_BITS-1:CH_BITS];
			s0_pix.blue  = s_tdata[3*CH_BITS-1:2*CH_BITS];
		end
	end

	assign s0_started   = int'(in_row_q) >= 2 || (in_row_q == RB'(1) && in_col_q != '0);
	assign col_end      = int'(in_col_q) + 1 >= int'(w_q);
	assign out_col_end  = out_col_q == w_q - WB'(1);
	assign out_row_last = out_row_q == h_q - HB'(1);
	assign s0_last      = out_row_last && out_col_end;
	assign s0_ctl.last  = s0_last;
	assign s0_ctl.border = out_row_q == '0 || out_row_last || out_col_q == '0 || out_col_end;

	assign col_ext  = {{AW{1'b0}}, in_col_q};
	assign ocol_ext = {{AW{1'b0}}, out_col_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q       <= WB'(W_RST);
			h_q       <= HB'(H_RST);
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_FRAME_WIDTH: begin
					w_q <= w_wr;
				end
				REG_FRAME_HEIGHT: begin
					h_q <= h_wr;
				end
				default: begin
				end
			endcase
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else if (in_beat) begin
			if (s0_started && s0_last) begin
				in_col_q  <= '0;
				in_row_q  <= '0;
				out_col_q <= '0;
				out_row_q <= '0;
			end else begin
				if (col_end) begin
					in_col_q <= '0;
					if (int'(in_row_q) < HMAX + 1) begin
						in_row_q <= in_row_q + RB'(1);
					end
				end else begin
					in_col_q <= in_col_q + WB'(1);
				end
				if (s0_started) begin
					if (out_col_end) begin
						out_col_q <= '0;
						out_row_q <= out_row_q + HB'(1);
					end else begin
						out_col_q <= out_col_q + WB'(1);
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1       <= 1'b0;
			started_s1 <= 1'b0;
		end else begin
			v_s1       <= in_beat;
			started_s1 <= s0_started;
		end
	end

	always_ff @(posedge clk) begin
		if (in_beat) begin
			cur_s1 <= s0_pix;
			ctl_s1 <= s0_ctl;
			col_s1 <= col_ext[AW-1:0];
		end
	end

	rmf_line_buf #(
		.DEPTH(MAX_WIDTH)
	) u_line_buf (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (in_beat),
		.rd_col   (col_ext[AW-1:0]),
		.rd_ocol  (ocol_ext[AW-1:0]),
		.wr_en    (v_s1),
		.wr_col   (col_s1),
		.wr_older (mid),
		.wr_newer (cur_s1),
		.top      (top),
		.mid      (mid),
		.copy     (copy)
	);

	// stage 1: slide the window one column and load the new right column
	always_comb begin
		win_n[0] = win_q[1];
		win_n[1] = win_q[2];
		win_n[2] = top;
		win_n[3] = win_q[4];
		win_n[4] = win_q[5];
		win_n[5] = mid;
		win_n[6] = win_q[7];
		win_n[7] = win_q[8];
		win_n[8] = cur_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
		end else if (v_s1) begin
			win_q <= win_n;
		end
	end

	rmf_median u_median (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s1 && started_s1),
		.win       (win_n),
		.copy      (copy),
		.ctl       (ctl_s1),
		.out_valid (med_valid),
		.beat      (med_beat),
		.inflight  (inflight)
	);

	rmf_out_fifo u_out_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (med_valid),
		.push_beat  (med_beat),
		.head_valid (m_tvalid),
		.head_ready (m_tready),
		.head_beat  (head_beat),
		.count      (fifo_cnt)
	);

	assign m_tdata = {head_beat.pix.blue, head_beat.pix.green, head_beat.pix.red};
	assign m_tlast = head_beat.last;

	// the credit on s_tready must keep the result queue from overflowing
	assert property (@(posedge clk) disable iff (!arst_n)
		med_valid |-> (int'(fifo_cnt) < OUT_DEPTH || (m_tvalid && m_tready)))
		else $error("result queue overflow");

	// column counters and the output row counter stay inside the configured frame
	assert property (@(posedge clk) disable iff (!arst_n)
		in_beat |-> (int'(in_col_q) < int'(w_q) && int'(out_col_q) < int'(w_q) &&
			int'(out_row_q) < int'(h_q)))
		else $error("position counter outside frame");

endmodule

// File: hdl/rmf_line_buf.sv
// Two line memories (rows r-2 and r-1) with registered reads and write forwarding.
module rmf_line_buf
	import rmf_pkg::*;
#(
	parameter int DEPTH = 320
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_col,
	input  logic [$clog2(DEPTH)-1:0] rd_ocol,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_col,
	input  pix_t                     wr_older,
	input  pix_t                     wr_newer,
	output pix_t                     top,
	output pix_t                     mid,
	output pix_t                     copy
);

	pix_t older_mem [DEPTH];
	pix_t newer_mem [DEPTH];

	pix_t older_a_q, older_b_q, newer_q;
	pix_t fwd_older_q, fwd_newer_q;
	logic fwd_a_q, fwd_b_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			older_mem[wr_col] <= wr_older;
			newer_mem[wr_col] <= wr_newer;
		end
		if (rd_en) begin
			older_a_q   <= older_mem[rd_col];
			older_b_q   <= older_mem[rd_ocol];
			newer_q     <= newer_mem[rd_col];
			fwd_older_q <= wr_older;
			fwd_newer_q <= wr_newer;
		end
	end

	// a write landing in the same cycle as the read wins over the stale read data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_a_q <= 1'b0;
			fwd_b_q <= 1'b0;
		end else if (rd_en) begin
			fwd_a_q <= wr_en && (wr_col == rd_col);
			fwd_b_q <= wr_en && (wr_col == rd_ocol);
		end
	end

	assign top  = fwd_a_q ? fwd_older_q : older_a_q;
	assign mid  = fwd_a_q ? fwd_newer_q : newer_q;
	assign copy = fwd_b_q ? fwd_older_q : older_b_q;

endmodule

// File: hdl/rmf_median.sv
// Rank-4 pick in the 3x3 window by R+G+B or border copy, two register stages.
module rmf_median
	import rmf_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  win_t      win,
	input  pix_t      copy,
	input  pos_ctl_t  ctl,
	output logic      out_valid,
	output out_beat_t beat,
	output logic [1:0] inflight
);

	logic                v_s2, v_s3;
	win_t                win_s2, win_s3;
	pix_t                copy_s2, copy_s3;
	pos_ctl_t            ctl_s2, ctl_s3;
	logic [SUM_BITS-1:0] sum_s2 [WIN_N];
	logic [WIN_N-1:0][WIN_N-1:0] ahead, ahead_s3;
	logic [RANK_BITS-1:0] rank [WIN_N];
	pix_t                med;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s2 <= in_valid;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid) begin
			win_s2  <= win;
			copy_s2 <= copy;
			ctl_s2  <= ctl;
			for (int i = 0; i < WIN_N; i++) begin
				sum_s2[i] <= pix_sum(win[i]);
			end
		end
		if (v_s2) begin
			win_s3   <= win_s2;
			copy_s3  <= copy_s2;
			ctl_s3   <= ctl_s2;
			ahead_s3 <= ahead;
		end
	end

	// ahead[i][j]: pixel j sorts before pixel i; ties go to the lower window slot
	always_comb begin
		for (int i = 0; i < WIN_N; i++) begin
			for (int j = 0; j < WIN_N; j++) begin
				if (j < i) begin
					ahead[i][j] = sum_s2[j] <= sum_s2[i];
				end else if (j > i) begin
					ahead[i][j] = sum_s2[j] < sum_s2[i];
				end else begin
					ahead[i][j] = 1'b0;
				end
			end
		end
	end

	always_comb begin
		med = '0;
		for (int i = 0; i < WIN_N; i++) begin
			rank[i] = '0;
			for (int j = 0; j < WIN_N; j++) begin
				rank[i] = rank[i] + RANK_BITS'(ahead_s3[i][j]);
			end
			if (rank[i] == RANK_BITS'(MED_RANK)) begin
				med = med | win_s3[i];
			end
		end
	end

	assign out_valid = v_s3;
	assign beat.last = ctl_s3.last;
	assign beat.pix  = ctl_s3.border ? copy_s3 : med;
	assign inflight  = 2'(v_s2) + 2'(v_s3);

endmodule

// File: hdl/rmf_out_fifo.sv
// Small result queue that decouples the pipeline from output backpressure.
module rmf_out_fifo
	import rmf_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	input  out_beat_t               push_beat,
	output logic                    head_valid,
	input  logic                    head_ready,
	output out_beat_t               head_beat,
	output logic [OUT_CNT_BITS-1:0] count
);

	out_beat_t                slot [OUT_DEPTH];
	logic [OUT_PTR_BITS-1:0]  wr_ptr_q, rd_ptr_q;
	logic [OUT_CNT_BITS-1:0]  cnt_q;
	logic                     pop;

	assign head_valid = cnt_q != '0;
	assign head_beat  = slot[rd_ptr_q];
	assign pop        = head_valid && head_ready;
	assign count      = cnt_q;

	always_ff @(posedge clk) begin
		if (push) begin
			slot[wr_ptr_q] <= push_beat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == OUT_PTR_BITS'(OUT_DEPTH - 1)) ? '0 :
					wr_ptr_q + OUT_PTR_BITS'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == OUT_PTR_BITS'(OUT_DEPTH - 1)) ? '0 :
					rd_ptr_q + OUT_PTR_BITS'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + OUT_CNT_BITS'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - OUT_CNT_BITS'(1);
			end
		end
	end

endmodule

// File: dv/tb.sv
// Self-checking testbench for the streaming RGB 3x3 median filter.
`timescale 1ns / 100ps

module tb;
	import rmf_pkg::*;

	localparam int MAX_W        = 320;
	localparam int MAX_H        = 240;
	localparam int N_DIRECTED   = 32;
	localparam int PLAN_BEATS   = 1775;
	localparam int SETTLE_CYC   = 16;
	localparam int CYCLE_LIMIT  = 400000;

	typedef enum int {STYLE_RANDOM, STYLE_TIES, STYLE_EXTREME} px_style_t;

	typedef struct packed {
		bit                        is_cfg;
		logic [CFG_IDX_BITS-1:0]   idx;
		logic [CFG_DATA_BITS-1:0]  val;
		pix_t                      px;
		logic                      drn;
		bit                        typed;
		out_beat_t                 want;
	} stim_row_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     s_tvalid = 1'b0;
	logic                     s_tready;
	logic [PIX_BITS-1:0]      s_tdata = '0;     // red, green, blue
	logic                     s_tuser = 1'b0;   // drain
	logic                     m_tvalid;
	logic                     m_tready = 1'b0;
	logic [PIX_BITS-1:0]      m_tdata;          // out_red, out_green, out_blue
	logic                     m_tlast;          // frame_end
	logic                     cfg_valid = 1'b0;
	logic                     cfg_ready;
	logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
	logic [CFG_DATA_BITS-1:0] cfg_data = '0;

	// predictor state
	pix_t        line_older [MAX_W];
	pix_t        line_newer [MAX_W];
	pix_t        win [WIN_N] = '{default: '0};
	int unsigned in_col = 0, in_row = 0, out_col = 0, out_row = 0;
	int unsigned reg_width = W_DEFAULT, reg_height = H_DEFAULT;

	out_beat_t   expected_pixels [$];
	int unsigned fail_count = 0, beats_sent = 0, pixels_checked = 0;
	int unsigned frame_ends = 0, cfg_writes = 0, cycle_count = 0;
	int unsigned send_idle_pct = 38, recv_idle_pct = 55;
	bit          stream_live = 0;

	rgb_median_filter_3x3 #(
		.MAX_WIDTH  (MAX_W),
		.MAX_HEIGHT (MAX_H)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	function automatic int unsigned eff_dim(int unsigned v, int unsigned hi);
		if (v < 1) return 1;
		if (v > hi) return hi;
		return v;
	endfunction

	function automatic int unsigned rgb_sum(pix_t p);
		return 32'(p.red) + 32'(p.green) + 32'(p.blue);
	endfunction

	// stable rank-4 pick by R+G+B, ties resolved in raster window order
	function automatic pix_t window_median();
		int unsigned si, sj, rank;
		for (int i = 0; i < WIN_N; i++) begin
			si = rgb_sum(win[i]);
			rank = 0;
			for (int j = 0; j < WIN_N; j++) begin
				sj = rgb_sum(win[j]);
				if (sj < si || (sj == si && j < i)) rank++;
			end
			if (rank == MED_RANK) return win[i];
		end
		return win[MED_RANK];
	endfunction

	function automatic void clear_position();
		in_col = 0;
		in_row = 0;
		out_col = 0;
		out_row = 0;
	endfunction

	function automatic bit predict_filtered(input pix_t px, input logic drn,
			output out_beat_t res);
		int unsigned w, h, col, ocol;
		pix_t cur, top, mid, copy;
		bit started, border, last;
		w = eff_dim(reg_width, MAX_W);
		h = eff_dim(reg_height, MAX_H);
		cur = (drn || in_row >= h) ? pix_t'(0) : px;
		col = (in_col < MAX_W) ? in_col : 0;
		ocol = (out_col < MAX_W) ? out_col : 0;
		top = line_older[col];
		mid = line_newer[col];
		copy = line_older[ocol];
		started = in_row >= 2 || (in_row == 1 && in_col >= 1);
		for (int r = 0; r < 3; r++) begin
			win[3*r] = win[3*r+1];
			win[3*r+1] = win[3*r+2];
		end
		win[2] = top;
		win[5] = mid;
		win[8] = cur;
		line_older[col] = mid;
		line_newer[col] = cur;
		in_col++;
		if (in_col >= w) begin
			in_col = 0;
			if (in_row < MAX_H + 2) in_row++;
		end
		res = '0;
		if (!started) return 0;
		border = out_row == 0 || out_row == h - 1 || out_col == 0 || out_col == w - 1;
		last = out_row == h - 1 && out_col == w - 1;
		res.pix = border ? copy : window_median();
		res.last = last;
		if (last) begin
			clear_position();
		end else begin
			out_col++;
			if (out_col >= w) begin
				out_col = 0;
				if (out_row < MAX_H) out_row++;
			end
		end
		return 1;
	endfunction

	// wait until the block has nothing in flight
	task automatic settle();
		s_tvalid <= 1'b0;
		stream_live = 0;
		while (expected_pixels.size() != 0) @(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
			input logic [CFG_DATA_BITS-1:0] val);
		if (stream_live) settle();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		if (idx == REG_FRAME_WIDTH) reg_width = val;
		else reg_height = val[CFG_H_BITS-1:0];
		clear_position();
		cfg_writes++;
	endtask

	task automatic send_pixel(input pix_t px, input logic drn, input bit typed,
			input out_beat_t typed_beat);
		out_beat_t pred;
		bit has_res;
		case (beats_sent * 3 / PLAN_BEATS)
			0: begin
				send_idle_pct = 38;
				recv_idle_pct = 55;
			end
			1: begin
				send_idle_pct = 55;
				recv_idle_pct = 38;
			end
			default: begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
		endcase
		cfg_valid <= 1'b0;
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {px.blue, px.green, px.red};
		s_tuser <= drn;
		stream_live = 1;
		do @(posedge clk); while (!s_tready);
		has_res = predict_filtered(px, drn, pred);
		if (typed) expected_pixels.push_back(typed_beat);
		else if (has_res) expected_pixels.push_back(pred);
		beats_sent++;
	endtask

	// result side: check each accepted beat, stall at random
	always @(posedge clk) begin
		out_beat_t want;
		pix_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got.red = m_tdata[CH_BITS-1:0];
			got.green = m_tdata[2*CH_BITS-1:CH_BITS];
			got.blue = m_tdata[3*CH_BITS-1:2*CH_BITS];
			if (expected_pixels.size() == 0) begin
				$error("result beat with nothing pending: red %0d green %0d blue %0d",
					got.red, got.green, got.blue);
				fail_count++;
			end else begin
				want = expected_pixels.pop_front();
				if (got.red !== want.pix.red) begin
					$error("out_red: expected %0d, got %0d", want.pix.red, got.red);
					fail_count++;
				end
				if (got.green !== want.pix.green) begin
					$error("out_green: expected %0d, got %0d", want.pix.green, got.green);
					fail_count++;
				end
				if (got.blue !== want.pix.blue) begin
					$error("out_blue: expected %0d, got %0d", want.pix.blue, got.blue);
					fail_count++;
				end
				if (m_tlast !== want.last) begin
					$error("frame_end: expected %0d, got %0d", want.last, m_tlast);
					fail_count++;
				end
			end
			pixels_checked++;
			if (m_tlast === 1'b1) frame_ends++;
		end
		m_tready <= ($urandom_range(99) >= recv_idle_pct);
	end

	function automatic stim_row_t px_row(int r, int g, int b, bit drn);
		stim_row_t row;
		row = '0;
		row.px = '{red: 8'(r), green: 8'(g), blue: 8'(b)};
		row.drn = drn;
		return row;
	endfunction

	function automatic stim_row_t known_row(int r, int g, int b, bit drn,
			int er, int eg, int eb, bit el);
		stim_row_t row;
		row = px_row(r, g, b, drn);
		row.typed = 1;
		row.want.pix = '{red: 8'(er), green: 8'(eg), blue: 8'(eb)};
		row.want.last = el;
		return row;
	endfunction

	function automatic stim_row_t reg_row(logic [CFG_IDX_BITS-1:0] idx, int val);
		stim_row_t row;
		row = '0;
		row.is_cfg = 1;
		row.idx = idx;
		row.val = CFG_DATA_BITS'(val);
		return row;
	endfunction

	initial begin
		stim_row_t dir_rows [N_DIRECTED];
		int unsigned wv, hv, we, he, frame_len, cut, frame_no, k;
		logic [CFG_DATA_BITS-1:0] hdata;
		px_style_t style;
		bit need_cfg;
		pix_t px;
		logic drn;

		dir_rows = '{
			// default 320x240 frame, abandoned by the register writes below
			px_row(0, 0, 0, 0), px_row(255, 255, 255, 0), px_row(18, 52, 86, 0),
			// zero dims act as 1x1: single pixel copied through
			reg_row(REG_FRAME_WIDTH, 0), reg_row(REG_FRAME_HEIGHT, 0),
			px_row(255, 0, 255, 0), px_row(1, 2, 3, 1),
			known_row(4, 5, 6, 1, 255, 0, 255, 1),
			// 2x2 is all border; last pixel is a drain inside the frame -> black
			reg_row(REG_FRAME_WIDTH, 2), reg_row(REG_FRAME_HEIGHT, 'h102),
			px_row(10, 20, 30, 0), px_row(255, 255, 255, 0), px_row(0, 0, 0, 0),
			known_row(77, 88, 99, 1, 10, 20, 30, 0),
			known_row(200, 100, 50, 0, 255, 255, 255, 0),
			known_row(0, 0, 0, 1, 0, 0, 0, 0),
			known_row(0, 0, 0, 1, 0, 0, 0, 1),
			// 3x3: center median picks a tied neighbor by window order
			reg_row(REG_FRAME_WIDTH, 3), reg_row(REG_FRAME_HEIGHT, 3),
			px_row(255, 255, 255, 0), px_row(0, 0, 0, 0), px_row(9, 9, 9, 0),
			px_row(30, 0, 0, 0),
			known_row(0, 0, 40, 0, 255, 255, 255, 0),
			known_row(0, 0, 30, 0, 0, 0, 0, 0),
			known_row(10, 10, 10, 0, 9, 9, 9, 0),
			known_row(200, 1, 1, 0, 30, 0, 0, 0),
			px_row(1, 1, 1, 0),
			known_row(0, 0, 0, 1, 0, 0, 30, 0),
			known_row(99, 99, 99, 0, 10, 10, 10, 0),
			known_row(0, 0, 0, 1, 200, 1, 1, 0),
			known_row(0, 0, 0, 1, 1, 1, 1, 1)
		};

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			if (dir_rows[i].is_cfg) write_reg(dir_rows[i].idx, dir_rows[i].val);
			else send_pixel(dir_rows[i].px, dir_rows[i].drn, dir_rows[i].typed,
				dir_rows[i].want);
		end

		frame_no = 0;
		need_cfg = 1;
		while (beats_sent < PLAN_BEATS) begin
			if (need_cfg || $urandom_range(99) < 70) begin
				k = $urandom_range(99);
				if (frame_no == 0) begin
					wv = 511;
					hv = 1;
				end else if (frame_no == 1) begin
					wv = 1;
					hv = MAX_H;
				end else if (k < 2) begin
					wv = $urandom_range(1) ? MAX_W : $urandom_range(MAX_W + 1, CFG_W_MAX);
					hv = $urandom_range(1, 2);
				end else if (k < 4) begin
					wv = $urandom_range(1, 3);
					hv = $urandom_range(1) ? MAX_H : $urandom_range(MAX_H + 1, CFG_H_MAX);
				end else if (k < 10) begin
					wv = $urandom_range(1) ? 0 : $urandom_range(1, 6);
					hv = (wv == 0) ? $urandom_range(0, 6) : 0;
				end else begin
					wv = $urandom_range(1, 10);
					hv = $urandom_range(1, 8);
				end
				hdata = CFG_DATA_BITS'(hv);
				hdata[CFG_DATA_BITS-1] = $urandom_range(1); // not part of the height
				if ($urandom_range(1)) begin
					write_reg(REG_FRAME_WIDTH, CFG_DATA_BITS'(wv));
					write_reg(REG_FRAME_HEIGHT, hdata);
				end else begin
					write_reg(REG_FRAME_HEIGHT, hdata);
					write_reg(REG_FRAME_WIDTH, CFG_DATA_BITS'(wv));
				end
			end
			we = eff_dim(reg_width, MAX_W);
			he = eff_dim(reg_height, MAX_H);
			frame_len = we * he + we + 1;
			cut = frame_len;
			need_cfg = 0;
			// now and then cut the frame short and restart it by a register write
			if (frame_no > 1 && $urandom_range(9) == 0) begin
				cut = $urandom_range(frame_len - 1);
				need_cfg = 1;
			end
			style = px_style_t'($urandom_range(STYLE_EXTREME));
			for (int n = 0; n < cut && beats_sent < PLAN_BEATS; n++) begin
				if (n < we * he) begin
					case (style)
						STYLE_TIES: begin
							px.red = 8'($urandom_range(3));
							px.green = 8'($urandom_range(3));
							px.blue = 8'($urandom_range(3));
						end
						STYLE_EXTREME: begin
							px.red = {CH_BITS{1'($urandom_range(1))}};
							px.green = {CH_BITS{1'($urandom_range(1))}};
							px.blue = {CH_BITS{1'($urandom_range(1))}};
						end
						default: begin
							px = PIX_BITS'($urandom);
						end
					endcase
					drn = ($urandom_range(29) == 0);
				end else begin
					px = PIX_BITS'($urandom);
					drn = ($urandom_range(5) != 0);
				end
				send_pixel(px, drn, 1'b0, '0);
			end
			frame_no++;
		end

		settle();
		$display("Sent %0d pixel beats in %0d frame setups with %0d register writes;",
			beats_sent, frame_no + 4, cfg_writes);
		$display("checked %0d filtered pixels, %0d of them frame ends.",
			pixels_checked, frame_ends);
		if (fail_count == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
